// ===== design/smfpm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smfpm_pkg
// Shared types and codes for the small fixed-point matrix multiply core.
// ----------------------------------------------------------------------------
package smfpm_pkg;

  // request kinds carried on s_axis_tuser
  localparam logic [1:0] REQ_WRITE_A = 2'd0;
  localparam logic [1:0] REQ_WRITE_B = 2'd1;
  localparam logic [1:0] REQ_COMPUTE = 2'd2;

  // configuration register indexes
  localparam logic CFG_DIMENSION  = 1'b0;
  localparam logic CFG_FRAC_SHIFT = 1'b1;

  localparam int IDX_W   = 2;
  localparam int VALUE_W = 32;
  localparam int TDATA_W = 40;
  localparam int CFG_W   = 5;
  localparam int DIM_W   = 3;
  localparam int SHIFT_W = 5;

  localparam logic [DIM_W-1:0] DIM_SMALL = 3'd3;

  // tags that travel alongside one multiply-accumulate term
  typedef struct packed {
    logic             first;
    logic             last_k;
    logic             last_el;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } mac_tag_t;

endpackage
`default_nettype wire

// ===== design/smfpm_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smfpm_ram
// Single-port-write, single-port-read memory with registered read data.
// ----------------------------------------------------------------------------
module smfpm_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== design/smfpm_mac.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smfpm_mac
// Pipelined multiply-accumulate: partial products, product, accumulator.
// Products and sums wrap to DATA_WIDTH bits.
// ----------------------------------------------------------------------------
module smfpm_mac #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  adv,
  input  wire logic                  in_valid,
  input  wire smfpm_pkg::mac_tag_t   in_tag,
  input  wire logic [DATA_WIDTH-1:0] a,
  input  wire logic [DATA_WIDTH-1:0] b,
  output logic                       done,
  output smfpm_pkg::mac_tag_t        done_tag,
  output logic [DATA_WIDTH-1:0]      acc
);

  import smfpm_pkg::*;

  localparam int H = (DATA_WIDTH + 1) / 2;

  logic                  v_m1;
  mac_tag_t              tag_m1;
  logic [DATA_WIDTH-1:0] prod_next;
  logic                  v_m2;
  mac_tag_t              tag_m2;
  logic [DATA_WIDTH-1:0] prod;

  generate
    if (DATA_WIDTH <= 32) begin : g_narrow
      logic [DATA_WIDTH-1:0] ll;
      always_ff @(posedge clk) begin
        if (adv) begin
          ll <= DATA_WIDTH'(a * b);
        end
      end
      assign prod_next = ll;
    end else begin : g_wide
      // low half of a wide product from three half-width multiplies
      logic [2*H-1:0] ae;
      logic [2*H-1:0] be;
      logic [2*H-1:0] ll;
      logic [H-1:0]   x1;
      logic [H-1:0]   x2;
      logic [H-1:0]   xs;
      assign ae = (2*H)'(a);
      assign be = (2*H)'(b);
      assign xs = H'(x1 + x2);
      always_ff @(posedge clk) begin
        if (adv) begin
          ll <= (2*H)'(ae[H-1:0]) * (2*H)'(be[H-1:0]);
          x1 <= H'(ae[H-1:0] * be[2*H-1:H]);
          x2 <= H'(ae[2*H-1:H] * be[H-1:0]);
        end
      end
      assign prod_next = DATA_WIDTH'(ll + ((2*H)'(xs) << H));
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      v_m1 <= 1'b0;
      v_m2 <= 1'b0;
      done <= 1'b0;
    end else if (adv) begin
      v_m1 <= in_valid;
      v_m2 <= v_m1;
      done <= v_m2 && tag_m2.last_k;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag_m1 <= in_tag;
      tag_m2 <= tag_m1;
      prod   <= prod_next;
      if (v_m2) begin
        acc      <= tag_m2.first ? prod : DATA_WIDTH'(acc + prod);
        done_tag <= tag_m2;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/small_matrix_fixed_point_multiply_core.sv =====
`default_nettype none
// Write transfers produce no result.
// A compute transfer holds the input off until its final MAC term issues; one
// MAC per cycle while the output is not stalled, set by the single read port of
// each element store. Synchronous active-high reset clears control only;
// stores are undefined until written, dimension resets to 4 and frac_shift to 0.
// ----------------------------------------------------------------------------
// small_matrix_fixed_point_multiply_core
// Loads matrices A and B into element stores and streams out the shifted,
// wrapped products C(r,c) = sum_k A(k,c) * B(r,k) in row-major order.
// ----------------------------------------------------------------------------
module small_matrix_fixed_point_multiply_core #(
  parameter int MAX_DIM    = 4,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic                            cfg_index,
  input  wire logic [smfpm_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [1:0] elem_row, [3:2] elem_col, [35:4] elem_value, [39:36] zero
  input  wire logic [smfpm_pkg::TDATA_W-1:0]   s_axis_tdata,
  // [1:0] req_type
  input  wire logic [1:0]                      s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [1:0] out_row, [3:2] out_col, [35:4] out_value, [39:36] zero
  output logic [smfpm_pkg::TDATA_W-1:0]        m_axis_tdata,
  output logic                                 m_axis_tlast
);

  import smfpm_pkg::*;

  localparam int CELLS = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(CELLS);

  logic [DIM_W-1:0]   dimension;
  logic [SHIFT_W-1:0] frac_shift;

  logic               busy;
  logic [IDX_W-1:0]   dim_m1;
  logic [IDX_W-1:0]   r;
  logic [IDX_W-1:0]   c;
  logic [IDX_W-1:0]   k;
  logic               adv;
  logic               in_xfer;
  logic               wr_ok;
  logic [IDX_W-1:0]   in_row;
  logic [IDX_W-1:0]   in_col;
  logic [AW-1:0]      waddr;
  logic signed [63:0] wval;
  logic [AW-1:0]      a_addr;
  logic [AW-1:0]      b_addr;
  logic               last_issue;

  logic                  v_s1;
  mac_tag_t              tag_s1;
  mac_tag_t              issue_tag;
  logic [DATA_WIDTH-1:0] a_rd;
  logic [DATA_WIDTH-1:0] b_rd;
  logic                  done;
  mac_tag_t              done_tag;
  logic [DATA_WIDTH-1:0] acc;
  logic signed [63:0]    acc_ext;
  logic signed [63:0]    shifted;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      dimension  <= 3'd4;
      frac_shift <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIMENSION:  dimension  <= cfg_data[DIM_W-1:0];
        CFG_FRAC_SHIFT: frac_shift <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // input side
  assign s_axis_tready = !busy;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign in_row        = s_axis_tdata[1:0];
  assign in_col        = s_axis_tdata[3:2];
  assign wr_ok         = in_xfer && ({1'b0, in_row} < 3'(MAX_DIM))
                         && ({1'b0, in_col} < 3'(MAX_DIM));
  assign waddr         = AW'(AW'(in_row) * AW'(MAX_DIM) + AW'(in_col));
  assign wval          = 64'(signed'(s_axis_tdata[35:4]));

  // issue sequencer: k innermost, then column, then row
  assign adv        = !m_axis_tvalid || m_axis_tready;
  assign last_issue = (r == dim_m1) && (c == dim_m1) && (k == dim_m1);
  assign a_addr     = AW'(AW'(k) * AW'(MAX_DIM) + AW'(c));
  assign b_addr     = AW'(AW'(r) * AW'(MAX_DIM) + AW'(k));

  assign issue_tag.first   = (k == '0);
  assign issue_tag.last_k  = (k == dim_m1);
  assign issue_tag.last_el = last_issue;
  assign issue_tag.row     = r;
  assign issue_tag.col     = c;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (in_xfer && s_axis_tuser == REQ_COMPUTE) begin
      busy <= 1'b1;
    end else if (busy && adv && last_issue) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && s_axis_tuser == REQ_COMPUTE) begin
      dim_m1 <= (dimension == DIM_SMALL) ? IDX_W'(2) : IDX_W'(MAX_DIM - 1);
      r      <= '0;
      c      <= '0;
      k      <= '0;
    end else if (busy && adv) begin
      if (k == dim_m1) begin
        k <= '0;
        if (c == dim_m1) begin
          c <= '0;
          r <= IDX_W'(r + 1'b1);
        end else begin
          c <= IDX_W'(c + 1'b1);
        end
      end else begin
        k <= IDX_W'(k + 1'b1);
      end
    end
  end

  smfpm_ram #(
    .DEPTH (CELLS),
    .WIDTH (DATA_WIDTH),
    .AW    (AW)
  ) u_ram_a (
    .clk   (clk),
    .we    (wr_ok && s_axis_tuser == REQ_WRITE_A),
    .waddr (waddr),
    .wdata (wval[DATA_WIDTH-1:0]),
    .re    (busy && adv),
    .raddr (a_addr),
    .rdata (a_rd)
  );

  smfpm_ram #(
    .DEPTH (CELLS),
    .WIDTH (DATA_WIDTH),
    .AW    (AW)
  ) u_ram_b (
    .clk   (clk),
    .we    (wr_ok && s_axis_tuser == REQ_WRITE_B),
    .waddr (waddr),
    .wdata (wval[DATA_WIDTH-1:0]),
    .re    (busy && adv),
    .raddr (b_addr),
    .rdata (b_rd)
  );

  // tags aligned with the registered read data
  always_ff @(posedge clk) begin
    if (rst) begin
      v_s1 <= 1'b0;
    end else if (adv) begin
      v_s1 <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag_s1 <= issue_tag;
    end
  end

  smfpm_mac #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mac (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (v_s1),
    .in_tag   (tag_s1),
    .a        (a_rd),
    .b        (b_rd),
    .done     (done),
    .done_tag (done_tag),
    .acc      (acc)
  );

  // arithmetic shift on the sign-extended sum, low 32 bits out
  assign acc_ext = 64'(signed'(acc));
  assign shifted = acc_ext >>> frac_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && done) begin
      m_axis_tdata <= {4'b0, shifted[VALUE_W-1:0], done_tag.col, done_tag.row};
      m_axis_tlast <= done_tag.last_el;
    end
  end

`ifndef SYNTH
  a_compute_starts: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && s_axis_tuser == REQ_COMPUTE) |=> busy)
    else $error("compute transfer did not start the sequencer");

  a_last_on_diagonal: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[1:0] == m_axis_tdata[3:2]))
    else $error("last marker away from the final diagonal element");

  a_issue_ends: assert property (@(posedge clk) disable iff (rst)
    (busy && adv && last_issue) |=> !busy)
    else $error("sequencer still busy after final issue");
`endif

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives element loads and compute requests into the matrix multiply core,
// predicts every result element from a local copy of both matrices and the
// size and shift registers, and compares each output transfer in order.
// ----------------------------------------------------------------------------
module testbench;
  import smfpm_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int MAX_DIM        = 4;
  localparam int CELLS          = MAX_DIM * MAX_DIM;
  localparam int SETTLE_CYCLES  = 100;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TOTAL_ITEMS    = 220;
  localparam int STALL_CYCLES   = 300;
  localparam int REPORT_LIMIT   = 10;
  localparam logic [31:0] CORNER_VALUES [5] =
    '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0000_0000, 32'h0000_0001};

  typedef struct {
    logic [1:0]  row;
    logic [1:0]  col;
    logic [31:0] value;
    logic        last;
  } product_elem_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic               cfg_index = 1'b0;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  // [1:0] elem_row, [3:2] elem_col, [35:4] elem_value, [39:36] zero
  logic [TDATA_W-1:0] s_axis_tdata = '0;
  // [1:0] req_type
  logic [1:0]         s_axis_tuser = 2'b00;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  // [1:0] out_row, [3:2] out_col, [35:4] out_value, [39:36] zero
  logic [TDATA_W-1:0] m_axis_tdata;
  logic               m_axis_tlast;

  // local copy of the block state
  logic [31:0]        store_a [CELLS];
  logic [31:0]        store_b [CELLS];
  logic [DIM_W-1:0]   dim_setting = 3'd4;
  logic [SHIFT_W-1:0] shift_setting = '0;

  product_elem_t expected_products [$];
  int  requests_sent = 0;
  int  faults = 0;
  int  quiet_cycles = 0;
  int  stall_left = 0;
  bit  stall_go = 1'b0;
  bit  no_idle = 1'b0;

  small_matrix_fixed_point_multiply_core u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [31:0] pick_value();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return CORNER_VALUES[$urandom_range(4)];
    if (sel < 4) return 32'($urandom_range(4095)) - 32'd2048;
    return $urandom;
  endfunction

  // updates the local stores, or queues every element of the product
  task automatic predict_request(input logic [1:0] kind, input logic [1:0] row,
                                 input logic [1:0] col, input logic [31:0] value);
    int n;
    logic [31:0] acc;
    product_elem_t p;
    case (kind)
      REQ_WRITE_A: store_a[{row, col}] = value;
      REQ_WRITE_B: store_b[{row, col}] = value;
      REQ_COMPUTE: begin
        n = (dim_setting == DIM_SMALL) ? 3 : MAX_DIM;
        for (int r = 0; r < n; r++) begin
          for (int c = 0; c < n; c++) begin
            acc = '0;
            for (int k = 0; k < n; k++)
              acc = acc + store_a[k * MAX_DIM + c] * store_b[r * MAX_DIM + k];
            p.row   = 2'(r);
            p.col   = 2'(c);
            p.value = $signed(acc) >>> shift_setting;
            p.last  = (r == n - 1) && (c == n - 1);
            expected_products.push_back(p);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_request(input logic [1:0] kind, input logic [1:0] row,
                              input logic [1:0] col, input logic [31:0] value);
    while (!no_idle && $urandom_range(99) < 7) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {4'b0000, value, col, row};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_request(kind, row, col, value);
    if (kind != REQ_UNUSED) requests_sent++;
  endtask

  // all results in, then room for a compute that is still winding down
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_products.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_register(input logic idx, input logic [CFG_W-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_DIMENSION) dim_setting = value[DIM_W-1:0];
    else shift_setting = value[SHIFT_W-1:0];
  endtask

  task automatic test_corner_elements();
    program_register(CFG_DIMENSION, CFG_W'(DIM_SMALL));
    program_register(CFG_FRAC_SHIFT, 5'd0);
    for (int i = 0; i < 9; i++) begin
      send_request(REQ_WRITE_A, 2'(i / 3), 2'(i % 3), CORNER_VALUES[i % 5]);
      send_request(REQ_WRITE_B, 2'(i % 3), 2'(i / 3), CORNER_VALUES[(i + 2) % 5]);
    end
    // outside the 3x3 window: stored but never read at this size
    send_request(REQ_WRITE_A, 2'd3, 2'd3, 32'h7fff_ffff);
    send_request(REQ_WRITE_B, 2'd3, 2'd0, 32'h8000_0000);
    send_request(REQ_UNUSED, 2'd3, 2'd3, 32'hffff_ffff);
    send_request(REQ_COMPUTE, 2'd0, 2'd0, 32'h0000_0000);
    program_register(CFG_FRAC_SHIFT, 5'd31);
    send_request(REQ_COMPUTE, 2'd3, 2'd3, 32'hffff_ffff);
    send_request(REQ_UNUSED, 2'd0, 2'd0, 32'h0000_0000);
    wait_idle();
  endtask

  task automatic test_full_size();
    // any size code but three selects the full matrix
    program_register(CFG_DIMENSION, 5'd0);
    program_register(CFG_FRAC_SHIFT, 5'($urandom_range(1, 30)));
    for (int i = 0; i < CELLS; i++) begin
      send_request(REQ_WRITE_A, 2'(i / MAX_DIM), 2'(i % MAX_DIM), pick_value());
      send_request(REQ_WRITE_B, 2'(i / MAX_DIM), 2'(i % MAX_DIM), pick_value());
    end
    send_request(REQ_COMPUTE, 2'($urandom), 2'($urandom), $urandom);
    program_register(CFG_DIMENSION, 5'd4);
    send_request(REQ_COMPUTE, 2'($urandom), 2'($urandom), $urandom);
    wait_idle();
  endtask

  // receiver holds off while requests keep coming, so the core backs up
  task automatic test_output_stall();
    stall_go = 1'b1;
    send_request(REQ_COMPUTE, 2'd1, 2'd2, 32'h0000_0000);
    for (int i = 0; i < 4; i++)
      send_request(i[0] ? REQ_WRITE_B : REQ_WRITE_A, 2'($urandom), 2'($urandom), pick_value());
    send_request(REQ_COMPUTE, 2'd0, 2'd0, 32'h0000_0000);
    send_request(REQ_COMPUTE, 2'd3, 2'd1, 32'h0000_0000);
    wait_idle();
  endtask

  task automatic test_random_jobs();
    int job;
    logic [CFG_W-1:0] dim_code;
    job = 0;
    while (requests_sent < TOTAL_ITEMS) begin
      no_idle = (job >= 6) && (job < 12);
      if (job % 4 == 3) begin
        if ($urandom_range(1) == 0) dim_code = CFG_W'(DIM_SMALL);
        else dim_code = 5'($urandom_range(7));
        program_register(CFG_DIMENSION, dim_code);
        case ($urandom_range(3))
          0:       program_register(CFG_FRAC_SHIFT, 5'd0);
          1:       program_register(CFG_FRAC_SHIFT, 5'd31);
          default: program_register(CFG_FRAC_SHIFT, 5'($urandom));
        endcase
      end
      repeat ($urandom_range(8)) begin
        if ($urandom_range(19) == 0)
          send_request(REQ_UNUSED, 2'($urandom), 2'($urandom), $urandom);
        else
          send_request($urandom_range(1) ? REQ_WRITE_B : REQ_WRITE_A,
                       2'($urandom), 2'($urandom), pick_value());
      end
      send_request(REQ_COMPUTE, 2'($urandom), 2'($urandom), $urandom);
      job++;
    end
    no_idle = 1'b0;
    wait_idle();
  endtask

  always @(posedge clk) begin
    if (stall_go) begin
      stall_left = STALL_CYCLES;
      stall_go   = 1'b0;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= no_idle || ($urandom_range(99) >= 7);
    end
  end

  always @(posedge clk) begin
    product_elem_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_products.size() == 0) begin
        faults++;
        if (faults <= REPORT_LIMIT)
          $display("unexpected result: row %0d col %0d value %h last %b",
                   m_axis_tdata[1:0], m_axis_tdata[3:2], m_axis_tdata[35:4], m_axis_tlast);
      end else begin
        want = expected_products.pop_front();
        if (m_axis_tdata[1:0] !== want.row || m_axis_tdata[3:2] !== want.col ||
            m_axis_tdata[35:4] !== want.value || m_axis_tlast !== want.last) begin
          faults++;
          if (faults <= REPORT_LIMIT)
            $display("mismatch: expected r%0d c%0d %h last %b, got r%0d c%0d %h last %b",
                     want.row, want.col, want.value, want.last,
                     m_axis_tdata[1:0], m_axis_tdata[3:2], m_axis_tdata[35:4], m_axis_tlast);
        end
      end
    end
  end

  // counts cycles with no transfer on either side and no register write
  always @(posedge clk) begin
    if (rst || cfg_we || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corner_elements();
    test_full_size();
    test_output_stall();
    test_random_jobs();
    wait_idle();
    if (faults == 0 && expected_products.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
